### rtl/lnps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lnps_pkg
// Shared types and codes for the last-note priority stack.
// ----------------------------------------------------------------------------
package lnps_pkg;

    typedef logic [6:0] note_t;
    typedef logic [6:0] vel_t;
    typedef logic [4:0] chan_t;
    typedef logic [1:0] kind_t;

    localparam logic OP_NOTE_ON  = 1'b0;
    localparam logic OP_NOTE_OFF = 1'b1;

    localparam kind_t KIND_GLIDE = 2'd0;
    localparam kind_t KIND_ON    = 2'd1;
    localparam kind_t KIND_OFF   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_SCAN,
        ST_OFF,
        ST_GLIDE,
        ST_ON
    } state_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/last_note_priority_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// last_note_priority_stack
// Held-note stack with last-note priority for a monophonic voice.
// ----------------------------------------------------------------------------
// Usage:
//   A key event is taken when start is high and busy is low. The event
//   fields are captured and busy stays high until its last result is out.
//   Results appear one per cycle with out_valid high for exactly one cycle;
//   the receiver must take them, there is no back-pressure.
//   Note-on: a push into the stack, then glide source and note-on results.
//   Note-off: the stack is walked through a chain of cells, one entry per
//   cycle from cell 0, once over every held note, then the note-off result
//   and, if the playing note was released while others remain held, a
//   glide source and a note-on.
//   The chain walk sets the rate for note-off events.
//   Reset empties the stack and clears the current note; the stack cells
//   themselves are not cleared, only entries below the held count are read.
// ----------------------------------------------------------------------------
module last_note_priority_stack #(
    parameter int STACK_DEPTH = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire                  opcode,
    input  lnps_pkg::note_t      note,
    input  lnps_pkg::vel_t       velocity,
    input  lnps_pkg::chan_t      channel,
    input  wire                  voice_active,
    input  lnps_pkg::note_t      voice_note,
    output logic                 out_valid,
    output lnps_pkg::kind_t      event_kind,
    output lnps_pkg::note_t      out_note,
    output lnps_pkg::vel_t       out_velocity,
    output lnps_pkg::chan_t      out_channel,
    output logic                 last
);
    import lnps_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] LAST_IDX  = CNT_W'(STACK_DEPTH - 1);

    state_t state_reg, state_next;

    logic             op_reg, op_next;
    note_t            note_reg, note_next;
    vel_t             vel_reg, vel_next;
    chan_t            chan_reg, chan_next;
    logic             act_reg, act_next;
    note_t            vnote_reg, vnote_next;

    logic [CNT_W-1:0] held_reg, held_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic             found_reg, found_next;
    note_t            cur_reg, cur_next;
    note_t            glide_reg, glide_next;
    note_t            newest_reg, newest_next;

    logic             shift_all;
    logic             load_en;
    logic [CNT_W-1:0] load_idx;
    note_t            load_data;
    note_t            head;
    logic             retrig;

    note_t            cell_data [STACK_DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++)
        begin : g_cell
            cell_ctrl_t ctrl;
            note_t      right;

            assign ctrl.shift = shift_all;
            assign ctrl.load  = load_en && (load_idx == CNT_W'(gi));

            if (gi == STACK_DEPTH - 1)
            begin : g_tail
                assign right = '0;
            end
            else
            begin : g_body
                assign right = cell_data[gi + 1];
            end

            lnps_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .right     (right),
                .load_data (load_data),
                .data      (cell_data[gi])
            );
        end
    endgenerate

    assign head   = cell_data[0];
    assign retrig = found_reg && (vnote_reg == note_reg) && (held_reg != '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (opcode == OP_NOTE_ON)
                    begin
                        state_next = ST_PUSH;
                    end
                    else if (held_reg == '0)
                    begin
                        state_next = ST_OFF;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_PUSH:
            begin
                state_next = ST_GLIDE;
            end
            ST_SCAN:
            begin
                if (rem_reg == CNT_W'(1))
                begin
                    state_next = ST_OFF;
                end
            end
            ST_OFF:
            begin
                state_next = retrig ? ST_GLIDE : ST_IDLE;
            end
            ST_GLIDE:
            begin
                state_next = ST_ON;
            end
            ST_ON:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and cell control
    always_comb
    begin
        op_next     = op_reg;
        note_next   = note_reg;
        vel_next    = vel_reg;
        chan_next   = chan_reg;
        act_next    = act_reg;
        vnote_next  = vnote_reg;
        held_next   = held_reg;
        rem_next    = rem_reg;
        found_next  = found_reg;
        cur_next    = cur_reg;
        glide_next  = glide_reg;
        newest_next = newest_reg;
        shift_all   = 1'b0;
        load_en     = 1'b0;
        load_idx    = '0;
        load_data   = note_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = opcode;
                    note_next  = note;
                    vel_next   = velocity;
                    chan_next  = channel;
                    act_next   = voice_active;
                    vnote_next = voice_note;
                    found_next = 1'b0;
                    rem_next   = held_reg;
                end
            end
            ST_PUSH:
            begin
                glide_next = act_reg ? cur_reg : note_reg;
                cur_next   = note_reg;
                load_en    = 1'b1;
                if (held_reg == DEPTH_CNT)
                begin
                    shift_all = 1'b1;
                    load_idx  = LAST_IDX;
                end
                else
                begin
                    load_idx  = held_reg;
                    held_next = held_reg + CNT_W'(1);
                end
            end
            ST_SCAN:
            begin
                shift_all = 1'b1;
                rem_next  = rem_reg - CNT_W'(1);
                if (head != note_reg)
                begin
                    load_en     = 1'b1;
                    load_idx    = held_reg - CNT_W'(1);
                    load_data   = head;
                    newest_next = head;
                end
                else
                begin
                    found_next = 1'b1;
                    held_next  = held_reg - CNT_W'(1);
                end
            end
            ST_OFF:
            begin
                if (retrig)
                begin
                    cur_next   = newest_reg;
                    glide_next = note_reg;
                end
            end
            ST_GLIDE, ST_ON:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy         = (state_reg != ST_IDLE);
        out_valid    = 1'b0;
        event_kind   = KIND_GLIDE;
        out_note     = '0;
        out_velocity = '0;
        out_channel  = chan_reg;
        last         = 1'b0;
        unique case (state_reg)
            ST_OFF:
            begin
                out_valid  = 1'b1;
                event_kind = KIND_OFF;
                out_note   = note_reg;
                last       = !retrig;
            end
            ST_GLIDE:
            begin
                out_valid  = 1'b1;
                event_kind = KIND_GLIDE;
                out_note   = glide_reg;
            end
            ST_ON:
            begin
                out_valid    = 1'b1;
                event_kind   = KIND_ON;
                out_note     = cur_reg;
                out_velocity = vel_reg;
                last         = 1'b1;
            end
            ST_IDLE, ST_PUSH, ST_SCAN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            held_reg  <= '0;
            cur_reg   <= '0;
            rem_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            cur_reg   <= cur_next;
            rem_reg   <= rem_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        note_reg   <= note_next;
        vel_reg    <= vel_next;
        chan_reg   <= chan_next;
        act_reg    <= act_next;
        vnote_reg  <= vnote_next;
        glide_reg  <= glide_next;
        newest_reg <= newest_next;
    end

`ifndef SYNTH
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= DEPTH_CNT)
        else $error("held count above stack depth");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (held_reg != '0) && (rem_reg != '0)
            && (rem_reg <= held_reg))
        else $error("scan with empty stack");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |=> !busy && !out_valid)
        else $error("transaction did not end after last result");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction without going busy");

    a_on_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH) |=> (state_reg == ST_GLIDE) && (op_reg == OP_NOTE_ON))
        else $error("note-on sequence broken");
`endif

endmodule

`default_nettype wire

### rtl/lnps_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lnps_cell
// One stack entry: loads a new note, takes its right neighbor, or holds.
// ----------------------------------------------------------------------------
module lnps_cell (
    input  wire                  clk,
    input  lnps_pkg::cell_ctrl_t ctrl,
    input  lnps_pkg::note_t      right,
    input  lnps_pkg::note_t      load_data,
    output lnps_pkg::note_t      data
);
    import lnps_pkg::*;

    note_t data_reg;
    note_t data_next;

    always_comb
    begin
        priority if (ctrl.load)
        begin
            data_next = load_data;
        end
        else if (ctrl.shift)
        begin
            data_next = right;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the last-note priority stack.
// Key events are queued up front and fed through the start/busy handshake by
// a driver. Sender gaps vary from phase to phase. A monitor runs a
// cycle-free model of the held-note stack on every accepted transaction. It
// checks each strobed result, field by field, against the oldest predicted
// event. The run covers a directed set, stack overflow and random phrases of
// key presses and releases with some noise mixed in.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lnps_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int RANDOM_KEYS = 135;

    typedef struct {
        logic  op;
        note_t note;
        vel_t  vel;
        chan_t chan;
        logic  vact;
        note_t vnote;
        bit    follow_voice;
        bit    pick_held;
        int    gap_pct;
    } key_event_t;

    typedef struct {
        kind_t kind;
        note_t note;
        vel_t  vel;
        chan_t chan;
        logic  last;
    } voice_event_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    logic  opcode = OP_NOTE_ON;
    note_t note = '0;
    vel_t  velocity = '0;
    chan_t channel = '0;
    logic  voice_active = 1'b0;
    note_t voice_note = '0;
    logic  out_valid;
    kind_t event_kind;
    note_t out_note;
    vel_t  out_velocity;
    chan_t out_channel;
    logic  last;

    key_event_t   key_q[$];
    voice_event_t voice_events_q[$];

    note_t held_notes[STACK_DEPTH];
    int    held_n = 0;
    note_t playing_note = '0;

    logic  took = 1'b0;
    int    err_count = 0;
    int    seg_gap = 0;

    last_note_priority_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .note         (note),
        .velocity     (velocity),
        .channel      (channel),
        .voice_active (voice_active),
        .voice_note   (voice_note),
        .out_valid    (out_valid),
        .event_kind   (event_kind),
        .out_note     (out_note),
        .out_velocity (out_velocity),
        .out_channel  (out_channel),
        .last         (last)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("%0t ns ERROR: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic void push_voice_event(input kind_t k, input note_t n,
                                             input vel_t v, input chan_t c,
                                             input logic l);
        voice_event_t ev;
        ev.kind = k;
        ev.note = n;
        ev.vel  = v;
        ev.chan = c;
        ev.last = l;
        voice_events_q.push_back(ev);
    endfunction

    // Stack update and emitted voice events for one key transaction
    function automatic void apply_key_event(input logic op, input note_t n,
                                            input vel_t v, input chan_t c,
                                            input logic act, input note_t vn);
        note_t glide_src;
        int    wr;
        bit    found;
        if (op == OP_NOTE_ON)
        begin
            glide_src = act ? playing_note : n;
            if (held_n >= STACK_DEPTH)
            begin
                for (int i = 0; i < STACK_DEPTH - 1; i++)
                    held_notes[i] = held_notes[i + 1];
                held_n = STACK_DEPTH - 1;
            end
            held_notes[held_n] = n;
            held_n++;
            playing_note = n;
            push_voice_event(KIND_GLIDE, glide_src, '0, c, 1'b0);
            push_voice_event(KIND_ON, n, v, c, 1'b1);
        end
        else
        begin
            wr = 0;
            found = 1'b0;
            for (int i = 0; i < held_n; i++)
            begin
                if (held_notes[i] == n)
                    found = 1'b1;
                else
                begin
                    held_notes[wr] = held_notes[i];
                    wr++;
                end
            end
            held_n = wr;
            if (found && vn == n && held_n > 0)
            begin
                playing_note = held_notes[held_n - 1];
                push_voice_event(KIND_OFF, n, '0, c, 1'b0);
                push_voice_event(KIND_GLIDE, n, '0, c, 1'b0);
                push_voice_event(KIND_ON, playing_note, v, c, 1'b1);
            end
            else
                push_voice_event(KIND_OFF, n, '0, c, 1'b1);
        end
    endfunction

    task automatic add_key(input logic op, input int n, input int v, input int c,
                           input logic act, input int vn, input bit follow,
                           input bit pick);
        key_event_t ke;
        ke.op           = op;
        ke.note         = note_t'(n);
        ke.vel          = vel_t'(v);
        ke.chan         = chan_t'(c);
        ke.vact         = act;
        ke.vnote        = note_t'(vn);
        ke.follow_voice = follow;
        ke.pick_held    = pick;
        ke.gap_pct      = seg_gap;
        key_q.push_back(ke);
    endtask

    // Driver: present the next key event when the last one was taken
    key_event_t nxt;
    always @(negedge clk)
    begin
        if (rst_n && (!start || took))
        begin
            if (key_q.size() > 0 && $urandom_range(99) >= key_q[0].gap_pct)
            begin
                nxt = key_q.pop_front();
                if (nxt.pick_held && held_n > 0)
                    nxt.note = held_notes[$urandom_range(held_n - 1)];
                if (nxt.follow_voice)
                begin
                    nxt.vact  = (held_n > 0);
                    nxt.vnote = playing_note;
                end
                opcode       <= nxt.op;
                note         <= nxt.note;
                velocity     <= nxt.vel;
                channel      <= nxt.chan;
                voice_active <= nxt.vact;
                voice_note   <= nxt.vnote;
                start        <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: predict on accept, check each strobed result
    voice_event_t want;
    always @(posedge clk)
    begin
        took <= start && !busy;
        if (rst_n)
        begin
            if (start && !busy)
                apply_key_event(opcode, note, velocity, channel, voice_active, voice_note);
            if (out_valid)
            begin
                if (voice_events_q.size() == 0)
                    report_mismatch($sformatf("unexpected result kind=%0d note=%0d",
                                              event_kind, out_note));
                else
                begin
                    want = voice_events_q.pop_front();
                    if (event_kind !== want.kind || out_note !== want.note ||
                        out_velocity !== want.vel || out_channel !== want.chan ||
                        last !== want.last)
                        report_mismatch($sformatf(
                            {"got kind=%0d note=%0d vel=%0d ch=%0d last=%0b, ",
                             "want %0d %0d %0d %0d %0b"},
                            event_kind, out_note, out_velocity, out_channel, last,
                            want.kind, want.note, want.vel, want.chan, want.last));
                end
            end
        end
    end

    initial
    begin
        int added;
        int sel;
        seg_gap = 0;
        add_key(OP_NOTE_ON, 0, 0, 1, 1'b0, 0, 1'b0, 1'b0);
        add_key(OP_NOTE_ON, 127, 127, 16, 1'b1, 0, 1'b0, 1'b0);
        add_key(OP_NOTE_ON, 127, 64, 5, 1'b1, 127, 1'b0, 1'b0);
        add_key(OP_NOTE_OFF, 127, 100, 9, 1'b1, 127, 1'b0, 1'b0);
        add_key(OP_NOTE_OFF, 55, 3, 2, 1'b1, 0, 1'b0, 1'b0);
        add_key(OP_NOTE_OFF, 0, 1, 3, 1'b1, 5, 1'b0, 1'b0);
        add_key(OP_NOTE_OFF, 0, 42, 4, 1'b0, 0, 1'b0, 1'b0);
        // overflow: one push past a full stack drops the oldest key
        for (int i = 0; i <= STACK_DEPTH; i++)
            add_key(OP_NOTE_ON, i * 7, i * 7, (i % 16) + 1, i[0], i * 3, 1'b0, 1'b0);
        add_key(OP_NOTE_OFF, STACK_DEPTH * 7, 77, 12, 1'b1, STACK_DEPTH * 7, 1'b0, 1'b0);

        added = 0;
        while (added < RANDOM_KEYS)
        begin
            case (added * 4 / RANDOM_KEYS)
                0: seg_gap = 0;
                1: seg_gap = 74;
                2: seg_gap = 24;
                default: seg_gap = 0;
            endcase
            sel = $urandom_range(99);
            if (sel < 12)
            begin
                add_key(1'($urandom_range(1)), $urandom_range(127), $urandom_range(127),
                        $urandom_range(16, 1), 1'($urandom_range(1)), $urandom_range(127),
                        1'b0, 1'b0);
                added++;
            end
            else if (sel < 20)
            begin
                repeat ($urandom_range(STACK_DEPTH + 4, STACK_DEPTH / 2))
                begin
                    add_key(OP_NOTE_ON, $urandom_range(127), $urandom_range(127),
                            $urandom_range(16, 1), 1'b0, 0, 1'b1, 1'b0);
                    added++;
                end
            end
            else if (sel < 58)
            begin
                add_key(OP_NOTE_ON,
                        ($urandom_range(1) != 0) ? $urandom_range(67, 60) : $urandom_range(127),
                        $urandom_range(127), $urandom_range(16, 1), 1'b0, 0, 1'b1, 1'b0);
                added++;
            end
            else
            begin
                add_key(OP_NOTE_OFF, $urandom_range(127), $urandom_range(127),
                        $urandom_range(16, 1), 1'($urandom_range(1)), $urandom_range(127),
                        ($urandom_range(7) != 0), 1'b1);
                added++;
            end
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do @(posedge clk);
        while (key_q.size() != 0 || start || voice_events_q.size() != 0);
        repeat (STACK_DEPTH + 8) @(posedge clk);

        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
